[src/hsim_pkg.sv]
`timescale 1ns / 1ps

package hsim_pkg;

    localparam int STORE_DEPTH  = 4096;
    localparam int SCALE_LEVELS = 64;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int WIDE_W       = 29;
    localparam int T_W          = 19;
    localparam int CFG_W        = 9;
    localparam int DIV_W        = 10;
    localparam int DIV_STEPS    = DIV_W;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [2:0] {
        REG_Y_CHANNEL_COUNT = 3'd0,
        REG_Y_PLANE_HEIGHT  = 3'd1,
        REG_Y_PLANE_WIDTH   = 3'd2,
        REG_CHAN_SHARE      = 3'd3,
        REG_Z_PLANE_HEIGHT  = 3'd4,
        REG_Z_PLANE_WIDTH   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic        func;
        logic [11:0] load_address;
        logic [15:0] half_bits;
        logic [6:0]  out_channel;
        logic [7:0]  row;
        logic [7:0]  col;
    } in_item_t;

    typedef struct packed {
        logic [5:0] scale_first;
        logic [5:0] scale_second;
        logic       fault;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0] y_channel_count;
        logic [CFG_W-1:0] y_plane_height;
        logic [CFG_W-1:0] y_plane_width;
        logic [CFG_W-1:0] chan_share;
        logic [CFG_W-1:0] z_plane_height;
        logic [CFG_W-1:0] z_plane_width;
    } cfg_t;

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_DROP,
        KIND_QUERY,
        KIND_FAULT
    } kind_t;

    typedef struct packed {
        kind_t    kind;
        in_item_t item;
    } entry_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [CFG_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_ADDR_T,
        S_ADDR_A,
        S_RD0,
        S_RD1,
        S_RD2,
        S_EMIT
    } back_state_t;

    typedef enum logic [2:0] {
        OP_RH,
        OP_RW,
        OP_SY,
        OP_SX,
        OP_C0,
        OP_C1
    } div_op_t;

endpackage

[src/hsim_front.sv]
`timescale 1ns / 1ps

module hsim_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  hsim_pkg::in_item_t       item,
    output logic                     full,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [2:0]               cfg_index,
    input  logic [hsim_pkg::CFG_W-1:0] cfg_data,
    input  logic                     q_full,
    output logic                     q_push,
    output hsim_pkg::entry_t         q_entry,
    output hsim_pkg::cfg_t           cfg
);

    hsim_pkg::cfg_t cfg_reg;
    hsim_pkg::cfg_t cfg_next;

    logic [7:0]                      half;
    logic                            query_bad;
    logic                            load_ok;
    logic [hsim_pkg::WIDE_W-1:0]     load_wide;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                hsim_pkg::REG_Y_CHANNEL_COUNT: cfg_next.y_channel_count = cfg_data;
                hsim_pkg::REG_Y_PLANE_HEIGHT:  cfg_next.y_plane_height  = cfg_data;
                hsim_pkg::REG_Y_PLANE_WIDTH:   cfg_next.y_plane_width   = cfg_data;
                hsim_pkg::REG_CHAN_SHARE:      cfg_next.chan_share      = cfg_data;
                hsim_pkg::REG_Z_PLANE_HEIGHT:  cfg_next.z_plane_height  = cfg_data;
                hsim_pkg::REG_Z_PLANE_WIDTH:   cfg_next.z_plane_width   = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.y_channel_count <= hsim_pkg::CFG_W'(2);
            cfg_reg.y_plane_height  <= hsim_pkg::CFG_W'(1);
            cfg_reg.y_plane_width   <= hsim_pkg::CFG_W'(1);
            cfg_reg.chan_share      <= hsim_pkg::CFG_W'(1);
            cfg_reg.z_plane_height  <= hsim_pkg::CFG_W'(1);
            cfg_reg.z_plane_width   <= hsim_pkg::CFG_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // query checks that depend on the fields and registers alone
    assign half      = cfg_reg.y_channel_count[8:1];
    assign query_bad = ({1'b0, item.out_channel} >= half)
                    || ({1'b0, item.row} >= cfg_reg.y_plane_height)
                    || ({1'b0, item.col} >= cfg_reg.y_plane_width)
                    || (cfg_reg.chan_share == '0)
                    || (cfg_reg.z_plane_height == '0)
                    || (cfg_reg.z_plane_width == '0);
    assign load_wide = hsim_pkg::WIDE_W'(item.load_address);
    assign load_ok   = load_wide < hsim_pkg::WIDE_W'(hsim_pkg::STORE_DEPTH);

    always_comb
    begin
        q_entry.item = item;
        if (item.func == hsim_pkg::FUNC_LOAD)
        begin
            q_entry.kind = load_ok ? hsim_pkg::KIND_LOAD : hsim_pkg::KIND_DROP;
        end
        else
        begin
            q_entry.kind = query_bad ? hsim_pkg::KIND_FAULT : hsim_pkg::KIND_QUERY;
        end
    end

    assign full   = q_full;
    assign q_push = push && !q_full;

endmodule

[src/hsim_queue.sv]
`timescale 1ns / 1ps

module hsim_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  hsim_pkg::entry_t wr_entry,
    output logic             full,
    input  logic             pop,
    output hsim_pkg::entry_t rd_entry,
    output logic             empty
);

    localparam int PTR_W = $clog2(hsim_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(hsim_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(hsim_pkg::QUEUE_DEPTH - 1);

    hsim_pkg::entry_t slots [hsim_pkg::QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = count_reg == CNT_W'(hsim_pkg::QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign rd_entry = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

[src/hsim_div.sv]
`timescale 1ns / 1ps

module hsim_div (
    input  logic               clk,
    input  logic               rst_n,
    input  hsim_pkg::div_req_t req,
    output hsim_pkg::div_rsp_t rsp
);

    localparam int CNT_W = $clog2(hsim_pkg::DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(hsim_pkg::DIV_STEPS - 1);

    logic                         busy_reg;
    logic                         done_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [hsim_pkg::CFG_W-1:0]   rem_reg;
    logic [hsim_pkg::DIV_W-1:0]   quo_reg;
    logic [hsim_pkg::CFG_W-1:0]   dsr_reg;

    logic [hsim_pkg::CFG_W:0]     trial;
    logic [hsim_pkg::CFG_W:0]     diff;
    logic                         ge;

    // restoring division, one quotient bit a cycle
    assign trial = {rem_reg, quo_reg[hsim_pkg::DIV_W-1]};
    assign ge    = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[hsim_pkg::CFG_W-1:0] : trial[hsim_pkg::CFG_W-1:0];
            quo_reg <= {quo_reg[hsim_pkg::DIV_W-2:0], ge};
        end
    end

endmodule

[src/hsim_back.sv]
`timescale 1ns / 1ps

module hsim_back (
    input  logic               clk,
    input  logic               rst_n,
    input  hsim_pkg::cfg_t     cfg,
    input  hsim_pkg::entry_t   q_entry,
    input  logic               q_empty,
    output logic               q_pop,
    output logic               busy,
    output logic               empty,
    input  logic               pop,
    output hsim_pkg::result_t  result
);

    localparam logic [10:0] SCALE_MAX = 11'(hsim_pkg::SCALE_LEVELS - 1);

    function automatic logic [5:0] scale_of(input logic [15:0] h);
        logic [4:0]  e;
        logic [9:0]  m;
        logic [10:0] v;
        logic [10:0] lvl;
        e = h[14:10];
        m = h[9:0];
        v = {1'b1, m} >> (5'd25 - e);
        if (e == 5'd31)
        begin
            lvl = (m != '0) ? '0 : SCALE_MAX;
        end
        else if (e < 5'd15)
        begin
            lvl = '0;
        end
        else if (e > 5'd25)
        begin
            lvl = SCALE_MAX;
        end
        else
        begin
            lvl = (v > SCALE_MAX) ? SCALE_MAX : v;
        end
        return lvl[5:0];
    endfunction

    hsim_pkg::back_state_t state_reg;
    hsim_pkg::back_state_t state_next;
    hsim_pkg::div_op_t     op_reg;
    hsim_pkg::div_req_t    div_req;
    hsim_pkg::div_rsp_t    div_rsp;
    hsim_pkg::in_item_t    item_reg;
    hsim_pkg::result_t     res_reg;
    hsim_pkg::result_t     res_value;

    logic                         res_valid_reg;
    logic                         res_valid_next;
    logic                         fault_reg;
    logic                         ch_sel_reg;
    logic [hsim_pkg::CFG_W-1:0]   rh_reg;
    logic [hsim_pkg::CFG_W-1:0]   rep_reg;
    logic [hsim_pkg::CFG_W-1:0]   sy_reg;
    logic [hsim_pkg::CFG_W-1:0]   sx_reg;
    logic [hsim_pkg::CFG_W-1:0]   ch0_reg;
    logic [hsim_pkg::CFG_W-1:0]   ch1_reg;
    logic [hsim_pkg::T_W-1:0]     t_reg;
    logic [hsim_pkg::WIDE_W-1:0]  a0_reg;
    logic [hsim_pkg::WIDE_W-1:0]  a1_reg;
    logic [15:0]                  rd_data_reg;
    logic [5:0]                   s0_reg;
    logic [5:0]                   s1_reg;

    logic [15:0]                  store [hsim_pkg::STORE_DEPTH];

    logic [7:0]                   half;
    logic [hsim_pkg::CFG_W-1:0]   c_hi;
    logic [hsim_pkg::CFG_W-1:0]   quo_low;
    logic [hsim_pkg::CFG_W-1:0]   zh_m1;
    logic [hsim_pkg::CFG_W-1:0]   zw_m1;
    logic [hsim_pkg::CFG_W-1:0]   ch_pick;
    logic [17:0]                  t_prod;
    logic [hsim_pkg::T_W-1:0]     t_calc;
    logic [27:0]                  a_prod;
    logic [hsim_pkg::WIDE_W-1:0]  a_calc;
    logic [hsim_pkg::WIDE_W-1:0]  load_wide;
    logic                         range_bad;
    logic                         mem_we;
    logic                         rd_en;
    logic [hsim_pkg::ADDR_W-1:0]  rd_idx;
    logic                         out_load;
    logic                         swap;
    logic                         div_start;

    hsim_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign half    = cfg.y_channel_count[8:1];
    assign c_hi    = {2'b00, item_reg.out_channel} + {1'b0, half};
    assign quo_low = div_rsp.quotient[hsim_pkg::CFG_W-1:0];
    assign zh_m1   = cfg.z_plane_height - hsim_pkg::CFG_W'(1);
    assign zw_m1   = cfg.z_plane_width - hsim_pkg::CFG_W'(1);

    // flat address (ch * zh + sy) * zw + sx, one multiply a step
    assign ch_pick = ch_sel_reg ? ch1_reg : ch0_reg;
    assign t_prod  = ch_pick * cfg.z_plane_height;
    assign t_calc  = {1'b0, t_prod} + hsim_pkg::T_W'(sy_reg);
    assign a_prod  = t_reg * cfg.z_plane_width;
    assign a_calc  = hsim_pkg::WIDE_W'(a_prod) + hsim_pkg::WIDE_W'(sx_reg);

    assign range_bad = (a0_reg >= hsim_pkg::WIDE_W'(hsim_pkg::STORE_DEPTH))
                    || (a1_reg >= hsim_pkg::WIDE_W'(hsim_pkg::STORE_DEPTH));
    assign load_wide = hsim_pkg::WIDE_W'(q_entry.item.load_address);

    always_comb
    begin
        div_req.start    = div_start;
        div_req.dividend = '0;
        div_req.divisor  = hsim_pkg::CFG_W'(1);
        case (op_reg)
            hsim_pkg::OP_RH:
            begin
                div_req.dividend = {1'b0, cfg.y_plane_height}
                                 + {1'b0, zh_m1};
                div_req.divisor  = cfg.z_plane_height;
            end
            hsim_pkg::OP_RW:
            begin
                div_req.dividend = {1'b0, cfg.y_plane_width}
                                 + {1'b0, zw_m1};
                div_req.divisor  = cfg.z_plane_width;
            end
            hsim_pkg::OP_SY:
            begin
                div_req.dividend = {2'b00, item_reg.row};
                div_req.divisor  = rep_reg;
            end
            hsim_pkg::OP_SX:
            begin
                div_req.dividend = {2'b00, item_reg.col};
                div_req.divisor  = rep_reg;
            end
            hsim_pkg::OP_C0:
            begin
                div_req.dividend = {3'b000, item_reg.out_channel};
                div_req.divisor  = cfg.chan_share;
            end
            hsim_pkg::OP_C1:
            begin
                div_req.dividend = {1'b0, c_hi};
                div_req.divisor  = cfg.chan_share;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hsim_pkg::S_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_entry.kind)
                        hsim_pkg::KIND_QUERY: state_next = hsim_pkg::S_DIV_GO;
                        hsim_pkg::KIND_FAULT: state_next = hsim_pkg::S_EMIT;
                        default:              state_next = hsim_pkg::S_IDLE;
                    endcase
                end
            end
            hsim_pkg::S_DIV_GO:
            begin
                state_next = hsim_pkg::S_DIV_WAIT;
            end
            hsim_pkg::S_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = (op_reg == hsim_pkg::OP_C1) ? hsim_pkg::S_ADDR_T
                                                             : hsim_pkg::S_DIV_GO;
                end
            end
            hsim_pkg::S_ADDR_T:
            begin
                state_next = hsim_pkg::S_ADDR_A;
            end
            hsim_pkg::S_ADDR_A:
            begin
                state_next = ch_sel_reg ? hsim_pkg::S_RD0 : hsim_pkg::S_ADDR_T;
            end
            hsim_pkg::S_RD0:
            begin
                state_next = range_bad ? hsim_pkg::S_EMIT : hsim_pkg::S_RD1;
            end
            hsim_pkg::S_RD1:
            begin
                state_next = hsim_pkg::S_RD2;
            end
            hsim_pkg::S_RD2:
            begin
                state_next = hsim_pkg::S_EMIT;
            end
            hsim_pkg::S_EMIT:
            begin
                if (out_load)
                begin
                    state_next = hsim_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = hsim_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        mem_we    = 1'b0;
        rd_en     = 1'b0;
        rd_idx    = a0_reg[hsim_pkg::ADDR_W-1:0];
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            hsim_pkg::S_IDLE:
            begin
                q_pop  = !q_empty;
                mem_we = !q_empty && (q_entry.kind == hsim_pkg::KIND_LOAD);
            end
            hsim_pkg::S_DIV_GO:
            begin
                div_start = 1'b1;
            end
            hsim_pkg::S_RD0:
            begin
                rd_en = !range_bad;
            end
            hsim_pkg::S_RD1:
            begin
                rd_en  = 1'b1;
                rd_idx = a1_reg[hsim_pkg::ADDR_W-1:0];
            end
            hsim_pkg::S_EMIT:
            begin
                out_load = !res_valid_reg || pop;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hsim_pkg::S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (out_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (pop)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            hsim_pkg::S_IDLE:
            begin
                item_reg   <= q_entry.item;
                fault_reg  <= q_entry.kind == hsim_pkg::KIND_FAULT;
                op_reg     <= hsim_pkg::OP_RH;
                ch_sel_reg <= 1'b0;
            end
            hsim_pkg::S_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    case (op_reg)
                        hsim_pkg::OP_RH:
                        begin
                            rh_reg <= quo_low;
                            op_reg <= hsim_pkg::OP_RW;
                        end
                        hsim_pkg::OP_RW:
                        begin
                            rep_reg <= (quo_low > rh_reg) ? quo_low : rh_reg;
                            op_reg  <= hsim_pkg::OP_SY;
                        end
                        hsim_pkg::OP_SY:
                        begin
                            sy_reg <= (div_rsp.quotient > {1'b0, zh_m1}) ? zh_m1 : quo_low;
                            op_reg <= hsim_pkg::OP_SX;
                        end
                        hsim_pkg::OP_SX:
                        begin
                            sx_reg <= (div_rsp.quotient > {1'b0, zw_m1}) ? zw_m1 : quo_low;
                            op_reg <= hsim_pkg::OP_C0;
                        end
                        hsim_pkg::OP_C0:
                        begin
                            ch0_reg <= quo_low;
                            op_reg  <= hsim_pkg::OP_C1;
                        end
                        hsim_pkg::OP_C1:
                        begin
                            ch1_reg <= quo_low;
                        end
                        default: ;
                    endcase
                end
            end
            hsim_pkg::S_ADDR_T:
            begin
                t_reg <= t_calc;
            end
            hsim_pkg::S_ADDR_A:
            begin
                if (ch_sel_reg)
                begin
                    a1_reg <= a_calc;
                end
                else
                begin
                    a0_reg     <= a_calc;
                    ch_sel_reg <= 1'b1;
                end
            end
            hsim_pkg::S_RD0:
            begin
                if (range_bad)
                begin
                    fault_reg <= 1'b1;
                end
            end
            hsim_pkg::S_RD1:
            begin
                s0_reg <= scale_of(rd_data_reg);
            end
            hsim_pkg::S_RD2:
            begin
                s1_reg <= scale_of(rd_data_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store[load_wide[hsim_pkg::ADDR_W-1:0]] <= q_entry.item.half_bits;
        end
        if (rd_en)
        begin
            rd_data_reg <= store[rd_idx];
        end
    end

    // checkerboard: odd parity swaps the two planes
    assign swap = item_reg.row[0] ^ item_reg.col[0];

    always_comb
    begin
        if (fault_reg)
        begin
            res_value.scale_first  = '0;
            res_value.scale_second = '0;
            res_value.fault        = 1'b1;
        end
        else
        begin
            res_value.scale_first  = swap ? s1_reg : s0_reg;
            res_value.scale_second = swap ? s0_reg : s1_reg;
            res_value.fault        = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_reg <= res_value;
        end
    end

    assign busy   = state_reg != hsim_pkg::S_IDLE;
    assign empty  = !res_valid_reg;
    assign result = res_reg;

endmodule

[src/hyperprior_scale_index_map.sv]
`timescale 1ns / 1ps
// Load: queued on acceptance, written to the store when the back end pops it; loads
// drain one per cycle while the back end is idle. Query: six serial 10-step divisions
// on the one shared divider, then address computation and store reads, give the result.
// A query that faults at the front goes straight to the result; one query in work at a time.
// Reset: control and configuration registers to reset values; store contents undefined.

module hyperprior_scale_index_map (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  hsim_pkg::in_item_t         item,
    output logic                       full,
    output logic                       empty,
    input  logic                       pop,
    output hsim_pkg::result_t          result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [2:0]                 cfg_index,
    input  logic [hsim_pkg::CFG_W-1:0] cfg_data
);

    hsim_pkg::entry_t q_wr_entry;
    hsim_pkg::entry_t q_rd_entry;
    hsim_pkg::cfg_t   cfg;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    logic back_busy;

    hsim_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_wr_entry),
        .cfg       (cfg)
    );

    hsim_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_wr_entry),
        .full     (q_full),
        .pop      (q_pop),
        .rd_entry (q_rd_entry),
        .empty    (q_empty)
    );

    hsim_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_entry (q_rd_entry),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .busy    (back_busy),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("back popped an empty queue");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.fault) |->
            (result.scale_first == 6'd0 && result.scale_second == 6'd0))
        else $error("faulted item carries non-zero scales");

    a_idle_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (q_full && !back_busy) |-> q_pop)
        else $error("idle back left a full queue");

endmodule
